// File: rtl/core/ttcw_pkg.sv
package ttcw_pkg;
	localparam int SLOTS = 16;
	localparam int FIXED_SLOTS = 4;
	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	localparam logic [3:0] K_TICK = 4'd0;
	localparam logic [3:0] K_SAMPLE = 4'd1;
	localparam logic [3:0] K_REG = 4'd2;
	localparam logic [3:0] K_UNREG = 4'd3;
	localparam logic [3:0] K_SETCUR = 4'd4;
	localparam logic [3:0] K_KILL = 4'd5;
	localparam logic [3:0] K_CHECK = 4'd6;
	localparam logic [3:0] K_FIND = 4'd7;
	localparam logic [3:0] K_BLOCK = 4'd8;
	localparam logic [3:0] K_UNBLOCK = 4'd9;
	localparam logic [3:0] K_READ = 4'd10;
	localparam logic [3:0] K_EXIT = 4'd11;

	localparam logic [2:0] S_OK = 3'd0;
	localparam logic [2:0] S_NOFREE = 3'd1;
	localparam logic [2:0] S_NOPID = 3'd2;
	localparam logic [2:0] S_NOKILL = 3'd3;
	localparam logic [2:0] S_INACT = 3'd4;

	localparam logic [1:0] ST_UNUSED = 2'd0;
	localparam logic [1:0] ST_READY = 2'd1;
	localparam logic [1:0] ST_BLOCKED = 2'd2;
	localparam logic [1:0] ST_ZOMBIE = 2'd3;

	localparam logic REG_PCT = 1'b0;
	localparam logic REG_LIM = 1'b1;

	typedef struct packed {
		logic        act;
		logic        ck;
		logic        stk;
		logic [1:0]  st;
		logic [15:0] pid;
		logic [15:0] tick;
		logic [15:0] prev;
		logic [31:0] acc;
		logic [7:0]  hog;
		logic        km;
	} entry_t;

	typedef enum logic [2:0] {
		F_IDLE, F_SUM, F_SUMW, F_PASS, F_PASSW, F_ONE, F_ONEW, F_DONE
	} fsm_t;
endpackage

// File: rtl/core/ttcw_mem.sv
module ttcw_mem (
	input  logic                  clk,
	input  logic                  we,
	input  logic [ttcw_pkg::SW-1:0] waddr,
	input  ttcw_pkg::entry_t      wdata,
	input  logic [ttcw_pkg::SW-1:0] raddr,
	output ttcw_pkg::entry_t      rdata
);
	import ttcw_pkg::*;
	entry_t mem [SLOTS];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/task_table_cpu_watchdog.sv
// channel  | ports                                                  | dir
// command  | start, kind, slot, pid_arg, may_kill, preemptive       | in
// result   | busy, done, status .. active_count                     | out
// config   | cfg_we, cfg_index, cfg_data                            | in
// One word at a time on the table memory (registered read, then write back).
// Per command: sample walks the table twice (sum, then update); find pid walks it once;
// kill pid walks it once, then acts on the entry found; others touch at most one entry.
// After reset a clearing pass over all SLOTS entries loads the reset entries, busy high.
// done pulses for one cycle with the result; the receiver cannot stall.
module task_table_cpu_watchdog (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  kind,
	input  logic [3:0]  slot,
	input  logic [15:0] pid_arg,
	input  logic        may_kill,
	input  logic        preemptive,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  slot_out,
	output logic [15:0] pid_out,
	output logic        killed_flag,
	output logic [1:0]  run_state,
	output logic [15:0] last_ticks,
	output logic [31:0] all_ticks,
	output logic [19:0] period_total,
	output logic [4:0]  newly_killed,
	output logic [4:0]  active_count
);
	import ttcw_pkg::*;

	fsm_t state_q, state_d;
	logic [6:0] pct_q;
	logic [7:0] lim_q;
	logic [SLOTS-1:0] act_q;
	logic [SW-1:0] idx_q;
	logic clr_q;
	logic [3:0] kind_q;
	logic [3:0] slot_q;
	logic [15:0] pida_q;
	logic mk_q, pre_q;
	logic [SW-1:0] cur_q;
	logic [15:0] pidc_q;
	logic [19:0] sum_q;
	logic [20:0] tot_q;
	logic [4:0] newly_q;
	logic found_q;
	logic [SW-1:0] fidx_q;
	entry_t rd_s2;

	logic we;
	logic [SW-1:0] waddr, raddr;
	entry_t wdata, rd;
	ttcw_mem u_mem (.clk, .we, .waddr, .wdata, .raddr, .rdata(rd));

	logic last_slot;
	assign last_slot = (idx_q == SW'(SLOTS - 1));
	logic in_range;
	assign in_range = ({1'b0, slot_q} < 5'(SLOTS));
	logic [SW-1:0] tgt;
	assign tgt = (kind_q == K_TICK || kind_q == K_EXIT) ? cur_q :
		(kind_q == K_KILL || kind_q == K_REG) ? fidx_q : slot_q[SW-1:0];

	logic pid_hit;
	assign pid_hit = act_q[idx_q] && rd.pid == pida_q;
	logic [20:0] tot_n;
	assign tot_n = tot_q + (act_q[idx_q] ? 21'(rd.tick) : 21'd0);

	// lowest free slot above the fixed ones
	logic free_hit;
	logic [SW-1:0] free_idx;
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= FIXED_SLOTS; i--)
			if (!act_q[i]) begin
				free_hit = 1'b1;
				free_idx = SW'(i);
			end
	end

	logic [22:0] prod;
	logic [27:0] thr;
	logic hog_hit;
	logic [7:0] hog_n;
	logic kill_now;
	assign prod = 23'(rd.tick) * 23'd100;
	// prod/total > pct  <=>  prod >= (pct+1)*total
	assign thr = 28'(pct_q + 8'd1) * 28'(sum_q);
	assign hog_hit = 28'(prod) >= thr;
	assign hog_n = (rd.hog == 8'hFF) ? rd.hog : rd.hog + 8'd1;
	assign kill_now = act_q[idx_q] && rd.ck && hog_hit && hog_n >= lim_q;

	logic [CW-1:0] cnt;
	always_comb begin
		cnt = '0;
		for (int i = 0; i < SLOTS; i++) cnt = cnt + CW'(act_q[i]);
	end

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = idx_q;
		raddr = idx_q;
		wdata = rd;
		case (state_q)
			F_IDLE: begin
				if (clr_q) begin
					we = 1'b1;
					wdata = '0;
					if (idx_q < SW'(FIXED_SLOTS)) begin
						wdata.act = 1'b1;
						wdata.pid = 16'(idx_q) + 16'd1;
					end
				end else if (start) begin
					if (kind == K_SAMPLE || kind == K_KILL || kind == K_FIND)
						state_d = F_SUM;
					else state_d = F_ONE;
				end
			end
			F_SUM: state_d = F_SUMW;
			F_SUMW: begin
				if (!last_slot) state_d = F_SUM;
				else if (kind_q == K_SAMPLE) state_d = F_PASS;
				else if (kind_q == K_KILL && (found_q || pid_hit)) state_d = F_ONE;
				else state_d = F_DONE;
			end
			F_PASS: state_d = F_PASSW;
			F_PASSW: begin
				state_d = last_slot ? F_DONE : F_PASS;
				if (act_q[idx_q]) begin
					we = 1'b1;
					wdata.acc = rd.acc + 32'(rd.tick);
					wdata.prev = rd.tick;
					wdata.tick = '0;
					if (rd.ck) begin
						wdata.hog = hog_hit ? hog_n : 8'd0;
						if (kill_now) begin
							wdata.km = 1'b1;
							if (rd.stk) wdata.st = ST_ZOMBIE;
						end
					end
				end
			end
			F_ONE: begin
				raddr = tgt;
				state_d = (kind_q == K_REG && !found_q) ? F_DONE : F_ONEW;
			end
			F_ONEW: begin
				waddr = tgt;
				state_d = F_DONE;
				case (kind_q)
					K_TICK: if (act_q[tgt] && rd.tick != 16'hFFFF) begin
						we = 1'b1; wdata.tick = rd.tick + 16'd1;
					end
					K_REG: begin
						we = 1'b1;
						wdata = '0;
						wdata.act = 1'b1;
						wdata.ck = mk_q;
						wdata.stk = pre_q;
						wdata.st = ST_READY;
						wdata.pid = pidc_q;
					end
					K_UNREG: if (in_range) begin
						we = 1'b1; wdata.st = ST_UNUSED;
					end
					K_KILL: if (rd.ck) begin
						we = 1'b1; wdata.km = 1'b1;
						if (rd.stk) wdata.st = ST_ZOMBIE;
					end
					K_CHECK: if (in_range) begin
						we = 1'b1; wdata.km = 1'b0;
					end
					K_BLOCK, K_UNBLOCK: if (in_range && act_q[tgt]) begin
						we = 1'b1;
						wdata.st = (kind_q == K_BLOCK) ? ST_BLOCKED : ST_READY;
					end
					K_EXIT: begin
						we = 1'b1; wdata.st = ST_ZOMBIE;
					end
					default: ;
				endcase
			end
			F_DONE: state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	assign busy = clr_q || state_q != F_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pct_q <= 7'd90;
			lim_q <= 8'd5;
			act_q <= '0;
			for (int i = 0; i < FIXED_SLOTS; i++) act_q[i] <= 1'b1;
			idx_q <= '0;
			clr_q <= 1'b1;
			cur_q <= '0;
			pidc_q <= 16'(FIXED_SLOTS + 1);
			sum_q <= 20'd1;
			done <= 1'b0;
			kind_q <= '0;
			slot_q <= '0;
			pida_q <= '0;
			mk_q <= 1'b0;
			pre_q <= 1'b0;
			tot_q <= '0;
			newly_q <= '0;
			found_q <= 1'b0;
			fidx_q <= '0;
			rd_s2 <= '0;
		end else begin
			state_q <= state_d;
			done <= (state_q == F_DONE);
			if (cfg_we) begin
				if (cfg_index == REG_PCT) pct_q <= cfg_data[6:0];
				else lim_q <= cfg_data;
			end
			case (state_q)
				F_IDLE: begin
					if (clr_q) begin
						if (last_slot) begin
							clr_q <= 1'b0; idx_q <= '0;
						end else idx_q <= idx_q + SW'(1);
					end else if (start) begin
						kind_q <= kind; slot_q <= slot; pida_q <= pid_arg;
						mk_q <= may_kill; pre_q <= preemptive;
						idx_q <= '0; tot_q <= '0; newly_q <= '0;
						found_q <= (kind == K_REG) && free_hit;
						fidx_q <= free_idx;
					end
				end
				F_SUMW: begin
					if (kind_q == K_SAMPLE) tot_q <= tot_n;
					else if (!found_q && pid_hit) begin
						found_q <= 1'b1; fidx_q <= idx_q;
					end
					if (last_slot) begin
						idx_q <= '0;
						if (kind_q == K_SAMPLE)
							sum_q <= (tot_n == 21'd0) ? 20'd1 :
								(tot_n > 21'hFFFFF) ? 20'hFFFFF : tot_n[19:0];
					end else idx_q <= idx_q + SW'(1);
				end
				F_PASSW: begin
					if (kill_now) begin
						newly_q <= newly_q + 5'd1;
						if (rd.stk) act_q[idx_q] <= 1'b0;
					end
					if (!last_slot) idx_q <= idx_q + SW'(1);
				end
				F_ONEW: begin
					rd_s2 <= rd;
					case (kind_q)
						K_REG: begin act_q[tgt] <= 1'b1; pidc_q <= pidc_q + 16'd1; end
						K_UNREG: if (in_range) begin
							act_q[tgt] <= 1'b0;
							if (cur_q == tgt) cur_q <= '0;
						end
						K_SETCUR: if (in_range) cur_q <= tgt;
						K_KILL: if (rd.ck && rd.stk) act_q[tgt] <= 1'b0;
						K_EXIT: act_q[tgt] <= 1'b0;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		status = S_OK; slot_out = '0; pid_out = '0; killed_flag = 1'b0;
		run_state = '0; last_ticks = '0; all_ticks = '0;
		period_total = sum_q; newly_killed = '0;
		active_count = 5'(cnt);
		case (kind_q)
			K_SAMPLE: newly_killed = newly_q;
			K_REG: if (found_q) begin
				slot_out = 4'(fidx_q); pid_out = pidc_q - 16'd1;
			end else status = S_NOFREE;
			K_UNREG, K_SETCUR: if (!in_range) status = S_INACT;
			K_KILL, K_FIND: if (!found_q) status = S_NOPID;
				else begin
					slot_out = 4'(fidx_q);
					if (kind_q == K_KILL && !rd_s2.ck) status = S_NOKILL;
				end
			K_CHECK: if (!in_range) status = S_INACT; else killed_flag = rd_s2.km;
			K_BLOCK, K_UNBLOCK: if (!in_range || !act_q[tgt]) status = S_INACT;
			K_READ: if (!in_range) status = S_INACT;
				else begin
					if (!act_q[tgt]) status = S_INACT;
					pid_out = rd_s2.pid; killed_flag = rd_s2.km;
					run_state = rd_s2.st; last_ticks = rd_s2.prev; all_ticks = rd_s2.acc;
				end
			default: ;
		endcase
	end
endmodule
